>>> hdl/hcim_pkg.sv
package hcim_pkg;

    // Grid order: the grid is 2^C_ORDER cells on a side (1..31).
    localparam int C_ORDER   = 31;
    localparam int C_WORD_W  = 2 * C_ORDER;
    localparam int C_COORD_W = 32;
    localparam int C_POS_W   = 62;

    typedef enum logic {
        OP_XY2IDX = 1'b0,
        OP_IDX2XY = 1'b1
    } t_op;

    // Data carried from cell to cell.
    // x/y: forward map keeps the unprocessed bits left-aligned and shifts left;
    //      inverse map builds the result top-down and shifts right.
    // word: forward map collects index digits at the bottom (shift left);
    //       inverse map consumes position digits from the bottom (shift right).
    typedef struct packed {
        t_op                 op;
        logic                bad;
        logic [C_ORDER-1:0]  x;
        logic [C_ORDER-1:0]  y;
        logic [C_WORD_W-1:0] word;
    } t_stage;

endpackage

>>> hdl/hcim_if.sv
interface hcim_req_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [hcim_pkg::C_COORD_W-1:0] x_coord;
    logic [hcim_pkg::C_COORD_W-1:0] y_coord;
    logic [hcim_pkg::C_POS_W-1:0]   curve_pos;

    modport source (output valid, opcode, x_coord, y_coord, curve_pos, input ready);
    modport sink   (input valid, opcode, x_coord, y_coord, curve_pos, output ready);
    modport mon    (input valid, ready, opcode, x_coord, y_coord, curve_pos);
endinterface

interface hcim_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [hcim_pkg::C_POS_W-1:0]   index_out;
    logic [hcim_pkg::C_COORD_W-1:0] x_out;
    logic [hcim_pkg::C_COORD_W-1:0] y_out;
    logic                          coord_invalid;

    modport source (output valid, index_out, x_out, y_out, coord_invalid, input ready);
    modport sink   (input valid, index_out, x_out, y_out, coord_invalid, output ready);
    modport mon    (input valid, ready, index_out, x_out, y_out, coord_invalid);
endinterface

>>> hdl/hcim_cell.sv
module hcim_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_odd_fwd,
    input  logic             i_odd_inv,
    input  logic             i_valid,
    input  hcim_pkg::t_stage i_data,
    output logic             o_valid,
    output hcim_pkg::t_stage o_data
);

    logic             r_valid;
    hcim_pkg::t_stage r_data;
    hcim_pkg::t_stage n_data;

    always_comb begin
        logic                         rx, ry, a, b, hx, hy;
        logic [1:0]                   q;
        logic [hcim_pkg::C_ORDER-1:0] sx, sy;
        n_data = i_data;
        rx = i_data.x[hcim_pkg::C_ORDER-1];
        ry = i_data.y[hcim_pkg::C_ORDER-1];
        a  = i_odd_fwd ? rx : ry;   // mirror side
        b  = i_odd_fwd ? ry : rx;   // swap side
        q  = 2'd0;
        sx = i_data.x;
        sy = i_data.y;
        hx = 1'b0;
        hy = 1'b0;
        if (i_data.op == hcim_pkg::OP_XY2IDX) begin
            // top bit decides the quadrant, rest moves up one place
            if (!a && !b) begin
                q  = 2'd0;
                sx = i_data.x;
                sy = i_data.y;
            end else if (b) begin
                q  = a ? 2'd2 : 2'd1;
                sx = i_data.y;
                sy = i_data.x;
            end else begin
                q  = 2'd3;
                sx = ~i_data.x;
                sy = ~i_data.y;
            end
            n_data.x    = sx << 1;
            n_data.y    = sy << 1;
            n_data.word = (i_data.word << 2) | hcim_pkg::C_WORD_W'(q);
        end else begin
            q = i_data.word[1:0];
            case (q)
                2'd0: begin
                    sx = i_data.x;
                    sy = i_data.y;
                end
                2'd1: begin
                    sx = i_data.y;
                    sy = i_data.x;
                    hx = !i_odd_inv;
                    hy = i_odd_inv;
                end
                2'd2: begin
                    sx = i_data.y;
                    sy = i_data.x;
                    hx = 1'b1;
                    hy = 1'b1;
                end
                default: begin
                    sx = ~i_data.x;
                    sy = ~i_data.y;
                    hx = i_odd_inv;
                    hy = !i_odd_inv;
                end
            endcase
            // new half-size bit lands on top; low garbage drains out below
            n_data.x    = (sx >> 1) | (hcim_pkg::C_ORDER'(hx) << (hcim_pkg::C_ORDER - 1));
            n_data.y    = (sy >> 1) | (hcim_pkg::C_ORDER'(hy) << (hcim_pkg::C_ORDER - 1));
            n_data.word = i_data.word >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> hdl/hilbert_curve_index_map.sv
// Hilbert-type curve index map, coordinates <-> curve position.
// A request passes through the row of registered cells from acceptance to result valid.
// Throughput: one request per cycle; the whole row stalls only while a
// result sits unaccepted at the output.
// Reset: synchronous, active low; clears every cell's valid bit, no result pending.
module hilbert_curve_index_map (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hcim_req_if.sink   i_req,
    hcim_rsp_if.source o_rsp
);

    localparam int N = hcim_pkg::C_ORDER;

    // Row of N cells. Cell j handles level ORDER-j of the forward map
    // (top bit first) and level j+1 of the inverse map (low digit first).
    logic             w_valid [N+1];
    hcim_pkg::t_stage w_data  [N+1];
    logic             w_adv;

    // Global advance: the last cell doubles as the output register.
    assign w_adv       = !w_valid[N] || o_rsp.ready;
    assign i_req.ready = w_adv;

    // Request conditioning: 1-based coords become 0-based, wrapped to ORDER bits.
    // A zero coordinate on the forward map is flagged and carried along.
    always_comb begin
        logic [hcim_pkg::C_COORD_W-1:0] xm, ym;
        xm = i_req.x_coord - hcim_pkg::C_COORD_W'(1);
        ym = i_req.y_coord - hcim_pkg::C_COORD_W'(1);
        w_valid[0]      = i_req.valid;
        w_data[0].op    = hcim_pkg::t_op'(i_req.opcode);
        w_data[0].bad   = 1'b0;
        w_data[0].x     = '0;
        w_data[0].y     = '0;
        w_data[0].word  = '0;
        if (i_req.opcode == hcim_pkg::OP_XY2IDX) begin
            w_data[0].bad = (i_req.x_coord == '0) || (i_req.y_coord == '0);
            w_data[0].x   = xm[N-1:0];
            w_data[0].y   = ym[N-1:0];
        end else begin
            // only the low 2*ORDER bits of the position count
            w_data[0].word = i_req.curve_pos[hcim_pkg::C_WORD_W-1:0];
        end
    end

    for (genvar j = 0; j < N; j++) begin : g_cell
        localparam logic ODD_FWD = 1'(((N - j) % 2) == 1);
        localparam logic ODD_INV = 1'(((j + 1) % 2) == 1);
        hcim_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (w_adv),
            .i_odd_fwd (ODD_FWD),
            .i_odd_inv (ODD_INV),
            .i_valid   (w_valid[j]),
            .i_data    (w_data[j]),
            .o_valid   (w_valid[j+1]),
            .o_data    (w_data[j+1])
        );
    end

    // Result formatting: fields that do not belong to the opcode read 0.
    always_comb begin
        o_rsp.valid         = w_valid[N];
        o_rsp.index_out     = '0;
        o_rsp.x_out         = '0;
        o_rsp.y_out         = '0;
        o_rsp.coord_invalid = 1'b0;
        if (w_data[N].op == hcim_pkg::OP_XY2IDX) begin
            o_rsp.coord_invalid = w_data[N].bad;
            if (!w_data[N].bad) begin
                o_rsp.index_out = hcim_pkg::C_POS_W'(w_data[N].word);
            end
        end else begin
            // back to 1-based
            o_rsp.x_out = hcim_pkg::C_COORD_W'(w_data[N].x) + hcim_pkg::C_COORD_W'(1);
            o_rsp.y_out = hcim_pkg::C_COORD_W'(w_data[N].y) + hcim_pkg::C_COORD_W'(1);
        end
    end

endmodule

>>> hdl/hcim_checker.sv
module hcim_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    hcim_req_if.sink   i_req,
    hcim_rsp_if.source o_rsp
);

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_rsp.valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid && $stable(o_rsp.index_out)
            && $stable(o_rsp.x_out) && $stable(o_rsp.y_out))
        else $error("stalled result changed");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |-> !i_req.ready)
        else $error("request taken while row stalled");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rsp.valid |-> i_req.ready)
        else $error("not ready with output empty");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.coord_invalid |->
            o_rsp.index_out == '0 && o_rsp.x_out == '0 && o_rsp.y_out == '0)
        else $error("flagged result carries data");

endmodule

bind hilbert_curve_index_map hcim_checker u_hcim_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_req   (i_req),
    .o_rsp   (o_rsp)
);
